[src/bbps_pkg.sv]
// Package for the buzzer beat pattern sequencer: operation and pattern codes,
// register indexes, reset values, and the shared configuration and item types.
// No dependencies.
`timescale 1ns / 1ps

package bbps_pkg;

	localparam int TIME_WIDTH = 16;
	localparam int REG_WIDTH  = 16;
	localparam int EXT_WIDTH  = (TIME_WIDTH > REG_WIDTH) ? TIME_WIDTH : REG_WIDTH;
	localparam int NUM_REGS   = 5;
	localparam int IDX_WIDTH  = 3;

	localparam logic [1:0] OP_MS_TICK   = 2'd0;
	localparam logic [1:0] OP_SET       = 2'd1;
	localparam logic [1:0] OP_TONE_TICK = 2'd2;

	localparam logic [2:0] PAT_OFF  = 3'd0;
	localparam logic [2:0] PAT_BEEP = 3'd1;
	localparam logic [2:0] PAT_FAST = 3'd2;
	localparam logic [2:0] PAT_SLOW = 3'd3;
	localparam logic [2:0] PAT_ON   = 3'd4;

	localparam logic [IDX_WIDTH-1:0] REG_BEEP_ON   = 3'd0;
	localparam logic [IDX_WIDTH-1:0] REG_LEAK_ON   = 3'd1;
	localparam logic [IDX_WIDTH-1:0] REG_LEAK_OFF  = 3'd2;
	localparam logic [IDX_WIDTH-1:0] REG_BREAK_ON  = 3'd3;
	localparam logic [IDX_WIDTH-1:0] REG_BREAK_OFF = 3'd4;

	localparam logic [REG_WIDTH-1:0] BEEP_ON_RST   = 16'd100;
	localparam logic [REG_WIDTH-1:0] LEAK_ON_RST   = 16'd200;
	localparam logic [REG_WIDTH-1:0] LEAK_OFF_RST  = 16'd200;
	localparam logic [REG_WIDTH-1:0] BREAK_ON_RST  = 16'd500;
	localparam logic [REG_WIDTH-1:0] BREAK_OFF_RST = 16'd1500;

	typedef struct packed {
		logic [REG_WIDTH-1:0] beep_on;
		logic [REG_WIDTH-1:0] leak_on;
		logic [REG_WIDTH-1:0] leak_off;
		logic [REG_WIDTH-1:0] break_on;
		logic [REG_WIDTH-1:0] break_off;
	} bbps_cfg_t;

	typedef struct packed {
		logic       advance;
		logic [1:0] operation;
		logic [2:0] pattern;
	} bbps_item_t;

endpackage

[src/buzzer_beat_pattern_sequencer_core.sv]
// Top level of the buzzer beat pattern sequencer: input register, handshake
// control, configuration registers and the pattern engine.
// Depends on bbps_pkg, bbps_cfg_regs and bbps_engine.
//
// Usage:
// Input channel in_valid/in_stall carries operation and pattern: a
// millisecond tick, a set-pattern command or a tone half-period tick.
// Output channel out_valid/out_stall returns one item per input item with
// pin_level, sounding, pattern_now and elapsed_ms after that item.
// An item is taken into the input register; its result is computed from it
// and held in the result register when the item advances. One item is
// accepted every cycle unless the receiver stalls, set by the single state
// update per cycle. While the receiver stalls, the result register holds and
// the input register holds one more item; in_stall rises once both are full.
// The user writes configuration registers through cfg_write/cfg_index/cfg_data
// only while the block is idle; the block does not enforce this. Indexes
// beyond the last register are ignored. Reset sets the engine state to pattern
// off, sound and pin low, elapsed time zero, and loads the default on/off times.
`timescale 1ns / 1ps

module buzzer_beat_pattern_sequencer_core import bbps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           operation,
	input  logic [2:0]           pattern,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 pin_level,
	output logic                 sounding,
	output logic [2:0]           pattern_now,
	output logic [REG_WIDTH-1:0] elapsed_ms,
	input  logic                 cfg_write,
	input  logic [IDX_WIDTH-1:0] cfg_index,
	input  logic [REG_WIDTH-1:0] cfg_data
);

	logic       valid_s1;
	logic [1:0] op_s1;
	logic [2:0] pat_s1;
	logic       res_valid_q;
	logic       advance;
	bbps_cfg_t  cfg;
	bbps_item_t item;

	assign advance  = valid_s1 && (!res_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1  <= operation;
			pat_s1 <= pattern;
		end
	end

	assign item.advance   = advance;
	assign item.operation = op_s1;
	assign item.pattern   = pat_s1;
	assign out_valid      = res_valid_q;

	bbps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bbps_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.item        (item),
		.pin_level   (pin_level),
		.sounding    (sounding),
		.pattern_now (pattern_now),
		.elapsed_ms  (elapsed_ms)
	);

endmodule

[src/bbps_cfg_regs.sv]
// Configuration register file of the buzzer beat pattern sequencer.
// Depends on bbps_pkg.
`timescale 1ns / 1ps

module bbps_cfg_regs import bbps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [IDX_WIDTH-1:0] cfg_index,
	input  logic [REG_WIDTH-1:0] cfg_data,
	output bbps_cfg_t            cfg
);

	bbps_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.beep_on   <= BEEP_ON_RST;
			cfg_q.leak_on   <= LEAK_ON_RST;
			cfg_q.leak_off  <= LEAK_OFF_RST;
			cfg_q.break_on  <= BREAK_ON_RST;
			cfg_q.break_off <= BREAK_OFF_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BEEP_ON:   cfg_q.beep_on   <= cfg_data;
				REG_LEAK_ON:   cfg_q.leak_on   <= cfg_data;
				REG_LEAK_OFF:  cfg_q.leak_off  <= cfg_data;
				REG_BREAK_ON:  cfg_q.break_on  <= cfg_data;
				REG_BREAK_OFF: cfg_q.break_off <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/bbps_engine.sv]
// Pattern state, next-state rule for one item, and the result register.
// Depends on bbps_pkg; configuration comes from bbps_cfg_regs.
`timescale 1ns / 1ps

module bbps_engine import bbps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bbps_cfg_t            cfg,
	input  bbps_item_t           item,
	output logic                 pin_level,
	output logic                 sounding,
	output logic [2:0]           pattern_now,
	output logic [REG_WIDTH-1:0] elapsed_ms
);

	localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};
	localparam logic [EXT_WIDTH-1:0]  OUT_MAX  = EXT_WIDTH'({REG_WIDTH{1'b1}});

	logic [2:0]            pat_q,   pat_d;
	logic                  sound_q, sound_d;
	logic [TIME_WIDTH-1:0] elap_q,  elap_d;
	logic                  bfin_q,  bfin_d;
	logic                  drive_q, drive_d;

	logic [TIME_WIDTH-1:0] elap_inc;
	logic [EXT_WIDTH-1:0]  elap_ext, elap_d_ext, on_lim, off_lim, beep_lim;

	assign elap_inc = (elap_q == TIME_MAX) ? elap_q : elap_q + 1'b1;
	assign elap_ext = EXT_WIDTH'(elap_inc);
	assign beep_lim = EXT_WIDTH'(cfg.beep_on);
	assign on_lim   = EXT_WIDTH'((pat_q == PAT_FAST) ? cfg.leak_on : cfg.break_on);
	assign off_lim  = EXT_WIDTH'((pat_q == PAT_FAST) ? cfg.leak_off : cfg.break_off);

	always_comb begin
		pat_d   = pat_q;
		sound_d = sound_q;
		elap_d  = elap_q;
		bfin_d  = bfin_q;
		drive_d = drive_q;
		case (item.operation)
			OP_MS_TICK: begin
				elap_d = elap_inc;
				case (pat_q)
					PAT_OFF: begin
						sound_d = 1'b0;
						drive_d = sound_q ? 1'b0 : drive_q;
					end
					PAT_ON: sound_d = 1'b1;
					PAT_BEEP: begin
						if (!bfin_q && sound_q && elap_ext >= beep_lim) begin
							sound_d = 1'b0;
							drive_d = 1'b0;
							bfin_d  = 1'b1;
							pat_d   = PAT_OFF;
						end
					end
					PAT_FAST, PAT_SLOW: begin
						if (sound_q && elap_ext >= on_lim) begin
							sound_d = 1'b0;
							drive_d = 1'b0;
							elap_d  = '0;
						end else if (!sound_q && elap_ext >= off_lim) begin
							sound_d = 1'b1;
							elap_d  = '0;
						end
					end
					default: ;
				endcase
			end
			OP_SET: begin
				if (item.pattern <= PAT_ON && item.pattern != pat_q) begin
					pat_d  = item.pattern;
					elap_d = '0;
					bfin_d = 1'b0;
					if (item.pattern == PAT_OFF) begin
						sound_d = 1'b0;
						drive_d = 1'b0;
					end else begin
						sound_d = 1'b1;
					end
				end
			end
			OP_TONE_TICK: drive_d = sound_q ? ~drive_q : drive_q;
			default: ;
		endcase
	end

	assign elap_d_ext = EXT_WIDTH'(elap_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q   <= PAT_OFF;
			sound_q <= 1'b0;
			elap_q  <= '0;
			bfin_q  <= 1'b0;
			drive_q <= 1'b0;
		end else if (item.advance) begin
			pat_q   <= pat_d;
			sound_q <= sound_d;
			elap_q  <= elap_d;
			bfin_q  <= bfin_d;
			drive_q <= drive_d;
		end
	end

	always_ff @(posedge clk) begin
		if (item.advance) begin
			pin_level   <= drive_d;
			sounding    <= sound_d;
			pattern_now <= pat_d;
			elapsed_ms  <= (elap_d_ext > OUT_MAX) ? {REG_WIDTH{1'b1}} : elap_d_ext[REG_WIDTH-1:0];
		end
	end

endmodule

[test/buzzer_beat_pattern_sequencer_core_test.sv]
// Self-checking testbench for buzzer_beat_pattern_sequencer_core: random commands,
// tone ticks and millisecond ticks under random sender gaps and receiver stalls.
// Depends on bbps_pkg and the core RTL; results are checked against a local predictor.
`timescale 1ns / 1ps

module buzzer_beat_pattern_sequencer_core_test;
	import bbps_pkg::*;

	localparam logic [1:0]           OP_UNUSED  = 2'd3;
	localparam logic [IDX_WIDTH-1:0] NO_REG     = 3'd7;
	localparam int                   QUIET_LIMIT = 20000;
	localparam int                   LONG_HOLD   = 400;

	typedef struct packed {
		logic [1:0] op;
		logic [2:0] pat;
	} buzz_cmd_t;

	typedef struct packed {
		logic                 pin;
		logic                 snd;
		logic [2:0]           pat;
		logic [REG_WIDTH-1:0] ms;
	} buzz_status_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           operation = OP_MS_TICK;
	logic [2:0]           pattern = PAT_OFF;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 pin_level;
	logic                 sounding;
	logic [2:0]           pattern_now;
	logic [REG_WIDTH-1:0] elapsed_ms;
	logic                 cfg_write = 1'b0;
	logic [IDX_WIDTH-1:0] cfg_index = REG_BEEP_ON;
	logic [REG_WIDTH-1:0] cfg_data = '0;

	buzz_cmd_t    pending_cmds[$];
	buzz_status_t expected_status[$];
	int           mismatches = 0;
	int           quiet_cycles = 0;
	int           holds_asked = 0;

	// predictor state
	logic [REG_WIDTH-1:0]  m_times [NUM_REGS] = '{BEEP_ON_RST, LEAK_ON_RST, LEAK_OFF_RST,
		BREAK_ON_RST, BREAK_OFF_RST};
	logic [2:0]            m_pattern = PAT_OFF;
	logic                  m_sound = 1'b0;
	logic [TIME_WIDTH-1:0] m_elapsed = '0;
	logic                  m_beep_done = 1'b0;
	logic                  m_pin = 1'b0;

	buzzer_beat_pattern_sequencer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.pattern(pattern),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pin_level(pin_level),
		.sounding(sounding),
		.pattern_now(pattern_now),
		.elapsed_ms(elapsed_ms),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic buzz_status_t step_buzzer(buzz_cmd_t c);
		buzz_status_t s;
		logic [REG_WIDTH-1:0] lim;
		case (c.op)
			OP_MS_TICK: begin
				if (m_elapsed != '1)
					m_elapsed++;
				case (m_pattern)
					PAT_OFF: begin
						m_sound = 1'b0;
						m_pin = m_sound ? m_pin : 1'b0;
					end
					PAT_ON: m_sound = 1'b1;
					PAT_BEEP: begin
						if (!m_beep_done && m_sound && m_elapsed >= m_times[REG_BEEP_ON]) begin
							m_sound = 1'b0;
							m_pin = 1'b0;
							m_beep_done = 1'b1;
							m_pattern = PAT_OFF;
						end
					end
					default: begin
						if (m_sound) begin
							lim = (m_pattern == PAT_FAST) ? m_times[REG_LEAK_ON] : m_times[REG_BREAK_ON];
							if (m_elapsed >= lim) begin
								m_sound = 1'b0;
								m_pin = 1'b0;
								m_elapsed = '0;
							end
						end else begin
							lim = (m_pattern == PAT_FAST) ? m_times[REG_LEAK_OFF] :
								m_times[REG_BREAK_OFF];
							if (m_elapsed >= lim) begin
								m_sound = 1'b1;
								m_elapsed = '0;
							end
						end
					end
				endcase
			end
			OP_SET: begin
				if (c.pat <= PAT_ON && c.pat != m_pattern) begin
					m_pattern = c.pat;
					m_elapsed = '0;
					m_beep_done = 1'b0;
					if (c.pat == PAT_OFF) begin
						m_sound = 1'b0;
						m_pin = 1'b0;
					end else begin
						m_sound = 1'b1;
					end
				end
			end
			OP_TONE_TICK: begin
				if (m_sound)
					m_pin = ~m_pin;
			end
			default: ;
		endcase
		s.pin = m_pin;
		s.snd = m_sound;
		s.pat = m_pattern;
		s.ms = (m_elapsed > 16'hFFFF) ? 16'hFFFF : REG_WIDTH'(m_elapsed);
		return s;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
	endtask

	// sender: bursts of random length separated by random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin : driver
		buzz_cmd_t next_cmd;
		if (arst_n && (!in_valid || !in_stall)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_cmds.size() > 0) begin
				next_cmd = pending_cmds.pop_front();
				in_valid <= 1'b1;
				operation <= next_cmd.op;
				pattern <= next_cmd.pat;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 :
						(($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) :
						$urandom_range(1, 6));
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall style changes now and then; long holds on request or at random
	int stall_clock = 0;
	int stall_style = 0;
	int holds_granted = 0;
	int hold_left = 0;

	always @(posedge clk) begin : receiver
		stall_clock <= stall_clock + 1;
		if (stall_clock % 300 == 0)
			stall_style <= $urandom_range(0, 3);
		if (holds_granted != holds_asked) begin
			holds_granted <= holds_granted + 1;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 5999) == 0) begin
			hold_left <= $urandom_range(40, 150);
			out_stall <= 1'b1;
		end else begin
			case (stall_style)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (stall_clock % 8 >= 5);
			endcase
		end
	end

	always @(posedge clk) begin : monitor
		buzz_status_t want;
		buzz_cmd_t    taken;
		if (arst_n) begin
			if (cfg_write && cfg_index < NUM_REGS)
				m_times[cfg_index] = cfg_data;
			if (out_valid && !out_stall) begin
				if (expected_status.size() == 0) begin
					report_mismatch("result with no item pending", 1, 0);
				end else begin
					want = expected_status.pop_front();
					if (pin_level !== want.pin)
						report_mismatch("pin_level", pin_level, want.pin);
					if (sounding !== want.snd)
						report_mismatch("sounding", sounding, want.snd);
					if (pattern_now !== want.pat)
						report_mismatch("pattern_now", pattern_now, want.pat);
					if (elapsed_ms !== want.ms)
						report_mismatch("elapsed_ms", elapsed_ms, want.ms);
				end
			end
			if (in_valid && !in_stall) begin
				taken.op = operation;
				taken.pat = pattern;
				expected_status.push_back(step_buzzer(taken));
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic push_cmd(input logic [1:0] op, input logic [2:0] pat);
		buzz_cmd_t c;
		c.op = op;
		c.pat = pat;
		pending_cmds.push_back(c);
	endtask

	task automatic drain();
		while (pending_cmds.size() != 0 || in_valid || expected_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [REG_WIDTH-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic load_times(input logic [REG_WIDTH-1:0] beep_on, leak_on, leak_off,
		break_on, break_off);
		write_reg(REG_BEEP_ON, beep_on);
		write_reg(REG_LEAK_ON, leak_on);
		write_reg(REG_LEAK_OFF, leak_off);
		write_reg(REG_BREAK_ON, break_on);
		write_reg(REG_BREAK_OFF, break_off);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [REG_WIDTH-1:0] pick_ms(input bit wide);
		if (wide && $urandom_range(0, 1) == 1)
			return REG_WIDTH'($urandom_range(0, 65535));
		return REG_WIDTH'($urandom_range(0, 6));
	endfunction

	// mostly a pattern change followed by a run of ticks, with some junk mixed in
	task automatic queue_rhythm_runs(input int wanted);
		int made;
		int run;
		made = 0;
		while (made < wanted) begin
			if ($urandom_range(0, 9) < 8) begin
				push_cmd(OP_SET, 3'($urandom_range(PAT_OFF, PAT_ON)));
				made++;
				run = $urandom_range(1, 30);
				repeat (run) begin
					if ($urandom_range(0, 2) == 0)
						push_cmd(OP_TONE_TICK, 3'($urandom));
					else
						push_cmd(OP_MS_TICK, 3'($urandom));
					made++;
				end
			end else if ($urandom_range(0, 1) == 0) begin
				push_cmd(OP_UNUSED, 3'($urandom));
			end else begin
				push_cmd(OP_SET, 3'($urandom_range(PAT_ON + 1, 7)));
			end
		end
	endtask

	initial begin : stimulus
		int phase;
		int ticks;
		while (!arst_n)
			@(posedge clk);

		// directed pass at reset times
		push_cmd(OP_TONE_TICK, PAT_OFF);
		push_cmd(OP_MS_TICK, PAT_OFF);
		push_cmd(OP_SET, PAT_OFF);
		push_cmd(OP_SET, 3'(PAT_ON + 1));
		push_cmd(OP_SET, 3'd7);
		push_cmd(OP_UNUSED, 3'd7);
		push_cmd(OP_SET, PAT_BEEP);
		push_cmd(OP_TONE_TICK, PAT_OFF);
		push_cmd(OP_TONE_TICK, PAT_OFF);
		push_cmd(OP_MS_TICK, PAT_OFF);
		push_cmd(OP_MS_TICK, 3'd7);
		push_cmd(OP_SET, PAT_BEEP);
		push_cmd(OP_TONE_TICK, PAT_OFF);
		push_cmd(OP_SET, PAT_ON);
		push_cmd(OP_MS_TICK, PAT_OFF);
		push_cmd(OP_TONE_TICK, PAT_OFF);
		push_cmd(OP_SET, PAT_FAST);
		push_cmd(OP_MS_TICK, PAT_OFF);
		push_cmd(OP_TONE_TICK, PAT_OFF);
		push_cmd(OP_SET, PAT_SLOW);
		push_cmd(OP_MS_TICK, PAT_OFF);
		push_cmd(OP_SET, PAT_OFF);
		push_cmd(OP_TONE_TICK, PAT_OFF);
		push_cmd(OP_MS_TICK, PAT_OFF);
		drain();

		// zero times: every phase ends on its first tick
		write_reg(NO_REG, REG_WIDTH'($urandom));
		load_times('0, '0, '0, '0, '0);
		queue_rhythm_runs(130);
		drain();

		for (phase = 0; phase < 4; phase++) begin
			load_times(pick_ms(0), pick_ms(0), pick_ms(0), pick_ms(0), pick_ms(0));
			if (phase == 0)
				holds_asked++;
			queue_rhythm_runs(110);
			drain();
		end

		for (phase = 0; phase < 2; phase++) begin
			load_times(pick_ms(1), pick_ms(1), pick_ms(1), pick_ms(1), pick_ms(1));
			queue_rhythm_runs(80);
			drain();
		end

		// largest times: beep keeps sounding across a run of ticks
		load_times('1, '1, '1, '1, '1);
		push_cmd(OP_SET, PAT_OFF);
		push_cmd(OP_SET, PAT_BEEP);
		for (ticks = 0; ticks < 30; ticks++) begin
			if (ticks % 7 == 0)
				push_cmd(OP_TONE_TICK, 3'($urandom));
			push_cmd(OP_MS_TICK, 3'($urandom));
		end
		push_cmd(OP_SET, PAT_FAST);
		push_cmd(OP_MS_TICK, PAT_OFF);
		push_cmd(OP_TONE_TICK, PAT_OFF);
		push_cmd(OP_SET, PAT_SLOW);
		push_cmd(OP_MS_TICK, PAT_OFF);
		push_cmd(OP_SET, PAT_ON);
		push_cmd(OP_TONE_TICK, PAT_OFF);
		drain();

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[buzzer_beat_pattern_sequencer_core.f]
src/bbps_pkg.sv
src/bbps_cfg_regs.sv
src/bbps_engine.sv
src/buzzer_beat_pattern_sequencer_core.sv
test/buzzer_beat_pattern_sequencer_core_test.sv
